>>> rtl/sfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sfd_pkg;

   localparam int unsigned HEADER_LEN = 28;
   localparam int unsigned FRAME_BUF  = 4096;
   localparam int unsigned CRC_LEN    = 4;

   localparam int unsigned BYTE_COUNT_W = 13;
   localparam int unsigned BODY_INDEX_W = 12;
   localparam int unsigned LEN_W        = 16;
   localparam int unsigned ID_W         = 16;
   localparam int unsigned CRC_W        = 32;
   localparam int unsigned SUM_W        = 18;

   localparam int unsigned ID_OFFSET  = 4;
   localparam int unsigned LEN_OFFSET = 8;

   localparam logic [7:0] SYNC0 = 8'hAA;
   localparam logic [7:0] SYNC1 = 8'h44;
   localparam logic [7:0] SYNC2 = 8'h12;

   localparam logic [ID_W-1:0] ID_RANGE_OBS = 16'd43;
   localparam logic [ID_W-1:0] ID_GPS_EPH   = 16'd7;
   localparam logic [ID_W-1:0] ID_BDS_EPH   = 16'd1696;
   localparam logic [ID_W-1:0] ID_BEST_POS  = 16'd42;

   localparam logic [CRC_W-1:0]        CRC_POLY_RESET = 32'hEDB88320;
   localparam logic [BODY_INDEX_W-1:0] MAX_BODY_RESET = 12'd4064;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic CSR_CRC_POLY = 1'b0;
   localparam logic CSR_MAX_BODY = 1'b1;

   typedef enum logic [2:0] {
      KIND_RANGE_OBS = 3'd0,
      KIND_GPS_EPH   = 3'd1,
      KIND_BDS_EPH   = 3'd2,
      KIND_BEST_POS  = 3'd3,
      KIND_OTHER     = 3'd4
   } kind_type;

   typedef struct packed {
      logic [CRC_W-1:0]        crc_poly;
      logic [BODY_INDEX_W-1:0] max_body_length;
   } cfg_type;

   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [7:0] b,
                                                 input logic [CRC_W-1:0] poly);
      logic [CRC_W-1:0] c;
      c = crc ^ {24'b0, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ poly;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   function automatic kind_type kind_of(input logic [ID_W-1:0] id);
      kind_type k;
      unique case (id)
         ID_RANGE_OBS: k = KIND_RANGE_OBS;
         ID_GPS_EPH:   k = KIND_GPS_EPH;
         ID_BDS_EPH:   k = KIND_BDS_EPH;
         ID_BEST_POS:  k = KIND_BEST_POS;
         default:      k = KIND_OTHER;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

>>> rtl/sfd_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

interface sfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic [11:0] body_index;
   logic [15:0] message_id;
   logic [2:0]  message_kind;
   logic        frame_end;
   logic        crc_ok;
   logic        epoch_end;

   modport source (output valid, output out_byte, output body_index, output message_id,
                   output message_kind, output frame_end, output crc_ok, output epoch_end,
                   input ready);
   modport sink (input valid, input out_byte, input body_index, input message_id,
                 input message_kind, input frame_end, input crc_ok, input epoch_end,
                 output ready);
endinterface

`default_nettype wire

>>> rtl/sfd_csr.sv
`timescale 1ns / 1ps
`default_nettype none

module sfd_csr
   import sfd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]           pwdata,
   output logic      [31:0]           prdata,
   output logic                       pready,
   output cfg_type                    cfg
);

   logic [CRC_W-1:0]        crc_poly_ff;
   logic [BODY_INDEX_W-1:0] max_body_ff;
   logic                    wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_poly_ff <= CRC_POLY_RESET;
         max_body_ff <= MAX_BODY_RESET;
      end else if (wr_en) begin
         unique case (paddr[2])
            CSR_CRC_POLY: crc_poly_ff <= pwdata;
            CSR_MAX_BODY: max_body_ff <= pwdata[BODY_INDEX_W-1:0];
            default:      crc_poly_ff <= crc_poly_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         CSR_CRC_POLY: prdata = crc_poly_ff;
         CSR_MAX_BODY: prdata = {{(32-BODY_INDEX_W){1'b0}}, max_body_ff};
         default:      prdata = '0;
      endcase
   end

   assign cfg.crc_poly        = crc_poly_ff;
   assign cfg.max_body_length = max_body_ff;

endmodule

`default_nettype wire

>>> rtl/sync_frame_deframer_crc32.sv
// sync_frame_deframer_crc32
//
// req_ch carries one receiver byte per transfer. The block hunts for the
// sync pattern AA 44 12, captures the header (message id and body length),
// and then emits one rsp_ch transfer per body byte with its index, the
// message id and the decoded message kind. After the four trailing CRC
// bytes it emits one frame-end transfer with crc_ok and epoch_end; a
// reflected CRC over crc_poly (zero initial value, no final XOR) covers
// header and body. Oversized frames give no transfers and hunting starts
// again. Sync and header bytes give none. Throughput is one byte per
// cycle while no result is stalled: each byte is held in the input
// register while the byte-wide CRC update and the framing state advance,
// and any result lands in the output register. While rsp_ch.ready is low
// with a result held, one further byte is taken into the input register
// and req_ch.ready then drops. The APB registers (crc_poly at 0,
// max_body_length at 4) must be written only while the stream is idle;
// the block does not enforce this. Synchronous reset returns the framer
// to hunting, drops pending bytes and results, restores register defaults.
`timescale 1ns / 1ps
`default_nettype none

module sync_frame_deframer_crc32
   import sfd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   sfd_req_if.sink                    req_ch,
   sfd_rsp_if.source                  rsp_ch,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]           pwdata,
   output logic      [31:0]           prdata,
   output logic                       pready
);

   typedef enum logic [2:0] {
      PH_HUNT0,
      PH_HUNT1,
      PH_HUNT2,
      PH_HEADER,
      PH_BODY,
      PH_CRC
   } phase_type;

   cfg_type cfg;

   logic                    in_valid_ff;
   logic [7:0]              in_byte_ff;
   logic                    advance;

   phase_type               phase_ff, phase_in;
   logic [BYTE_COUNT_W-1:0] byte_count_ff, byte_count_in;
   logic [CRC_W-1:0]        crc_ff, crc_in;
   logic [ID_W-1:0]         id_ff, id_in;
   logic [LEN_W-1:0]        len_ff, len_in;
   logic [CRC_W-1:0]        rcrc_ff, rcrc_in;

   logic                    out_valid_ff;
   logic [7:0]              out_byte_ff;
   logic [BODY_INDEX_W-1:0] body_index_ff, body_index_in;
   logic [ID_W-1:0]         message_id_ff;
   kind_type                kind_ff, kind_in;
   logic                    frame_end_ff, frame_end_in;
   logic                    crc_ok_ff, crc_ok_in;
   logic                    epoch_end_ff, epoch_end_in;
   logic                    emit_in;

   logic [CRC_W-1:0]        crc_step;
   logic [CRC_W-1:0]        crc_first;
   logic [BYTE_COUNT_W-1:0] count_inc;
   logic [BYTE_COUNT_W-1:0] body_pos;
   logic [BYTE_COUNT_W-1:0] trail_pos;
   logic [SUM_W-1:0]        frame_sum;
   logic                    too_long;

   sfd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   assign crc_step  = crc_byte(crc_ff, in_byte_ff, cfg.crc_poly);
   assign crc_first = crc_byte('0, in_byte_ff, cfg.crc_poly);
   assign count_inc = byte_count_ff + BYTE_COUNT_W'(1);
   assign body_pos  = byte_count_ff - BYTE_COUNT_W'(HEADER_LEN);
   assign trail_pos = body_pos - len_ff[BYTE_COUNT_W-1:0];

   always_comb begin
      phase_in      = phase_ff;
      byte_count_in = byte_count_ff;
      crc_in        = crc_ff;
      id_in         = id_ff;
      len_in        = len_ff;
      rcrc_in       = rcrc_ff;
      emit_in       = 1'b0;
      body_index_in = '0;
      frame_end_in  = 1'b0;
      crc_ok_in     = 1'b0;
      frame_sum     = '0;
      too_long      = 1'b0;
      unique case (phase_ff)
         PH_HUNT0: begin
            if (in_byte_ff == SYNC0) begin
               phase_in      = PH_HUNT1;
               crc_in        = crc_first;
               byte_count_in = BYTE_COUNT_W'(1);
            end
         end
         PH_HUNT1: begin
            priority if (in_byte_ff == SYNC1) begin
               phase_in      = PH_HUNT2;
               crc_in        = crc_step;
               byte_count_in = BYTE_COUNT_W'(2);
            end else if (in_byte_ff == SYNC0) begin
               phase_in      = PH_HUNT1;
               crc_in        = crc_first;
               byte_count_in = BYTE_COUNT_W'(1);
            end else begin
               phase_in = PH_HUNT0;
            end
         end
         PH_HUNT2: begin
            priority if (in_byte_ff == SYNC2) begin
               phase_in      = PH_HEADER;
               crc_in        = crc_step;
               byte_count_in = BYTE_COUNT_W'(3);
               id_in         = '0;
               len_in        = '0;
               rcrc_in       = '0;
            end else if (in_byte_ff == SYNC0) begin
               phase_in      = PH_HUNT1;
               crc_in        = crc_first;
               byte_count_in = BYTE_COUNT_W'(1);
            end else begin
               phase_in = PH_HUNT0;
            end
         end
         PH_HEADER: begin
            crc_in        = crc_step;
            byte_count_in = count_inc;
            if (byte_count_ff == BYTE_COUNT_W'(ID_OFFSET)) begin
               id_in[7:0] = in_byte_ff;
            end
            if (byte_count_ff == BYTE_COUNT_W'(ID_OFFSET + 1)) begin
               id_in[15:8] = in_byte_ff;
            end
            if (byte_count_ff == BYTE_COUNT_W'(LEN_OFFSET)) begin
               len_in[7:0] = in_byte_ff;
            end
            if (byte_count_ff == BYTE_COUNT_W'(LEN_OFFSET + 1)) begin
               len_in[15:8] = in_byte_ff;
            end
            frame_sum = SUM_W'(HEADER_LEN) + SUM_W'(len_in) + SUM_W'(CRC_LEN);
            too_long  = (len_in > LEN_W'(cfg.max_body_length)) ||
                        (frame_sum > SUM_W'(FRAME_BUF));
            if (count_inc >= BYTE_COUNT_W'(HEADER_LEN)) begin
               priority if (too_long) begin
                  phase_in = PH_HUNT0;
               end else if (len_in == '0) begin
                  phase_in = PH_CRC;
               end else begin
                  phase_in = PH_BODY;
               end
            end
         end
         PH_BODY: begin
            crc_in        = crc_step;
            byte_count_in = count_inc;
            emit_in       = 1'b1;
            body_index_in = body_pos[BODY_INDEX_W-1:0];
            if ((LEN_W'(body_pos) + LEN_W'(1)) >= len_ff) begin
               phase_in = PH_CRC;
            end
         end
         PH_CRC: begin
            rcrc_in       = rcrc_ff | (CRC_W'(in_byte_ff) << {trail_pos[1:0], 3'b000});
            byte_count_in = count_inc;
            if (trail_pos[1:0] == 2'd3) begin
               emit_in      = 1'b1;
               frame_end_in = 1'b1;
               crc_ok_in    = (rcrc_in == crc_ff);
               phase_in     = PH_HUNT0;
            end
         end
         default: begin
            phase_in = PH_HUNT0;
         end
      endcase
   end

   assign kind_in      = kind_of(id_ff);
   assign epoch_end_in = crc_ok_in && (kind_in == KIND_RANGE_OBS);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         phase_ff      <= PH_HUNT0;
         byte_count_ff <= '0;
         crc_ff        <= '0;
         id_ff         <= '0;
         len_ff        <= '0;
         rcrc_ff       <= '0;
      end else begin
         if (req_ch.ready) begin
            in_valid_ff <= req_ch.valid;
         end
         if (advance) begin
            phase_ff      <= phase_in;
            byte_count_ff <= byte_count_in;
            crc_ff        <= crc_in;
            id_ff         <= id_in;
            len_ff        <= len_in;
            rcrc_ff       <= rcrc_in;
         end
         if (!out_valid_ff || rsp_ch.ready) begin
            out_valid_ff <= advance && emit_in;
         end
      end
      if (req_ch.valid && req_ch.ready) begin
         in_byte_ff <= req_ch.in_byte;
      end
      if (advance && emit_in) begin
         out_byte_ff   <= in_byte_ff;
         body_index_ff <= body_index_in;
         message_id_ff <= id_ff;
         kind_ff       <= kind_in;
         frame_end_ff  <= frame_end_in;
         crc_ok_ff     <= crc_ok_in;
         epoch_end_ff  <= epoch_end_in;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.out_byte     = out_byte_ff;
   assign rsp_ch.body_index   = body_index_ff;
   assign rsp_ch.message_id   = message_id_ff;
   assign rsp_ch.message_kind = kind_ff;
   assign rsp_ch.frame_end    = frame_end_ff;
   assign rsp_ch.crc_ok       = crc_ok_ff;
   assign rsp_ch.epoch_end    = epoch_end_ff;

endmodule

`default_nettype wire

>>> rtl/sfd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module sfd_protocol_checker
   import sfd_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [7:0]  rsp_out_byte,
   input wire logic [11:0] rsp_body_index,
   input wire logic [2:0]  rsp_message_kind,
   input wire logic        rsp_frame_end,
   input wire logic        rsp_crc_ok,
   input wire logic        rsp_epoch_end
);

   // a stalled result transfer keeps its byte, body index and frame-end flag
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_body_index) && $stable(rsp_frame_end))
      else $error("rsp payload changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

   a_epoch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_epoch_end |->
         rsp_frame_end && rsp_crc_ok && (rsp_message_kind == KIND_RANGE_OBS))
      else $error("epoch end without good range frame end");

   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_crc_ok || rsp_body_index != '0) |->
         (rsp_frame_end == rsp_crc_ok || !rsp_crc_ok) && !(rsp_frame_end && rsp_body_index != '0))
      else $error("frame end flags inconsistent with body index");

endmodule

bind sync_frame_deframer_crc32 sfd_protocol_checker u_sfd_protocol_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_out_byte     (rsp_ch.out_byte),
   .rsp_body_index   (rsp_ch.body_index),
   .rsp_message_kind (rsp_ch.message_kind),
   .rsp_frame_end    (rsp_ch.frame_end),
   .rsp_crc_ok       (rsp_ch.crc_ok),
   .rsp_epoch_end    (rsp_ch.epoch_end)
);

`default_nettype wire

>>> bench/sfd_checker.sv
`timescale 1ns / 1ps

module sfd_checker
   import sfd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   sfd_req_if                    req_ch,
   sfd_rsp_if                    rsp_ch,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic                  pready,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output int unsigned           failures,
   output int unsigned           waiting,
   output int unsigned           frames_passed,
   output int unsigned           frames_failed,
   output int unsigned           body_bytes
);

   typedef enum logic [2:0] {
      HUNT_AA,
      HUNT_44,
      HUNT_12,
      IN_HEADER,
      IN_BODY,
      IN_CRC
   } framer_phase_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [11:0] body_index;
      logic [15:0] message_id;
      kind_type    message_kind;
      logic        frame_end;
      logic        crc_ok;
      logic        epoch_end;
   } deframed_type;

   deframed_type     deframed_q[$];
   deframed_type     got;
   deframed_type     want;
   logic [31:0]      poly;
   logic [11:0]      max_body;
   framer_phase_type phase;
   logic [12:0]      frame_pos;
   logic [31:0]      crc_acc;
   logic [15:0]      msg_id;
   logic [15:0]      msg_len;
   logic [31:0]      crc_rx;
   int unsigned      n_err      = 0;
   int unsigned      n_reported = 0;
   int unsigned      n_pass     = 0;
   int unsigned      n_fail     = 0;
   int unsigned      n_body     = 0;

   function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b,
                                             input logic [31:0] p);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      repeat (8) c = c[0] ? ((c >> 1) ^ p) : (c >> 1);
      return c;
   endfunction

   function automatic kind_type kind_for(input logic [15:0] id);
      case (id)
         ID_RANGE_OBS: return KIND_RANGE_OBS;
         ID_GPS_EPH:   return KIND_GPS_EPH;
         ID_BDS_EPH:   return KIND_BDS_EPH;
         ID_BEST_POS:  return KIND_BEST_POS;
         default:      return KIND_OTHER;
      endcase
   endfunction

   task automatic start_frame(input logic [7:0] b);
      phase     = HUNT_44;
      crc_acc   = crc_update(32'd0, b, poly);
      frame_pos = 13'd1;
   endtask

   task automatic framer_byte(input logic [7:0] b);
      deframed_type r;
      logic [12:0]  idx;
      logic [1:0]   k;
      r              = '0;
      r.message_id   = msg_id;
      r.message_kind = kind_for(msg_id);
      case (phase)
         HUNT_AA: begin
            if (b == SYNC0) start_frame(b);
         end
         HUNT_44: begin
            if (b == SYNC1) begin
               crc_acc   = crc_update(crc_acc, b, poly);
               frame_pos = 13'd2;
               phase     = HUNT_12;
            end else if (b == SYNC0) begin
               start_frame(b);
            end else begin
               phase = HUNT_AA;
            end
         end
         HUNT_12: begin
            if (b == SYNC2) begin
               crc_acc   = crc_update(crc_acc, b, poly);
               frame_pos = 13'd3;
               msg_id    = '0;
               msg_len   = '0;
               crc_rx    = '0;
               phase     = IN_HEADER;
            end else if (b == SYNC0) begin
               start_frame(b);
            end else begin
               phase = HUNT_AA;
            end
         end
         IN_HEADER: begin
            crc_acc = crc_update(crc_acc, b, poly);
            if (frame_pos == ID_OFFSET)      msg_id[7:0]   = b;
            if (frame_pos == ID_OFFSET + 1)  msg_id[15:8]  = b;
            if (frame_pos == LEN_OFFSET)     msg_len[7:0]  = b;
            if (frame_pos == LEN_OFFSET + 1) msg_len[15:8] = b;
            frame_pos = frame_pos + 13'd1;
            if (frame_pos >= HEADER_LEN) begin
               if (msg_len > max_body || HEADER_LEN + msg_len + CRC_LEN > FRAME_BUF) begin
                  phase = HUNT_AA;
               end else if (msg_len == 0) begin
                  phase = IN_CRC;
               end else begin
                  phase = IN_BODY;
               end
            end
         end
         IN_BODY: begin
            idx       = 13'(frame_pos - HEADER_LEN);
            crc_acc   = crc_update(crc_acc, b, poly);
            frame_pos = frame_pos + 13'd1;
            if (idx + 1 >= msg_len) phase = IN_CRC;
            r.out_byte   = b;
            r.body_index = idx[11:0];
            deframed_q.push_back(r);
            n_body++;
         end
         IN_CRC: begin
            k         = 2'(frame_pos - HEADER_LEN - msg_len);
            crc_rx    = crc_rx | ({24'd0, b} << (8 * k));
            frame_pos = frame_pos + 13'd1;
            if (k == 2'd3) begin
               phase       = HUNT_AA;
               r.out_byte  = b;
               r.frame_end = 1'b1;
               r.crc_ok    = (crc_rx == crc_acc);
               r.epoch_end = r.crc_ok && r.message_kind == KIND_RANGE_OBS;
               deframed_q.push_back(r);
               if (r.crc_ok) n_pass++;
               else n_fail++;
            end
         end
         default: phase = HUNT_AA;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         deframed_q.delete();
         poly      = CRC_POLY_RESET;
         max_body  = MAX_BODY_RESET;
         phase     = HUNT_AA;
         frame_pos = '0;
         crc_acc   = '0;
         msg_id    = '0;
         msg_len   = '0;
         crc_rx    = '0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr[CSR_ADDR_W-1:2] == CSR_MAX_BODY) max_body = pwdata[11:0];
            else poly = pwdata;
         end
         if (req_ch.valid && req_ch.ready) framer_byte(req_ch.in_byte);
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.out_byte     = rsp_ch.out_byte;
            got.body_index   = rsp_ch.body_index;
            got.message_id   = rsp_ch.message_id;
            got.message_kind = kind_type'(rsp_ch.message_kind);
            got.frame_end    = rsp_ch.frame_end;
            got.crc_ok       = rsp_ch.crc_ok;
            got.epoch_end    = rsp_ch.epoch_end;
            if (deframed_q.size() == 0) begin
               n_err++;
               if (n_reported < 10)
                  $display("%0t: unexpected transfer byte %h idx %0d id %0d end %b",
                           $realtime, got.out_byte, got.body_index, got.message_id,
                           got.frame_end);
               n_reported++;
            end else begin
               want = deframed_q.pop_front();
               if (got.out_byte !== want.out_byte || got.body_index !== want.body_index ||
                   got.message_id !== want.message_id ||
                   got.message_kind !== want.message_kind ||
                   got.frame_end !== want.frame_end || got.crc_ok !== want.crc_ok ||
                   got.epoch_end !== want.epoch_end) begin
                  n_err++;
                  if (n_reported < 10) begin
                     $display("%0t: mismatch exp byte %h idx %0d id %0d kind %0d end %b ok %b ep %b",
                              $realtime, want.out_byte, want.body_index, want.message_id,
                              want.message_kind, want.frame_end, want.crc_ok, want.epoch_end);
                     $display("%0t:          got byte %h idx %0d id %0d kind %0d end %b ok %b ep %b",
                              $realtime, got.out_byte, got.body_index, got.message_id,
                              got.message_kind, got.frame_end, got.crc_ok, got.epoch_end);
                  end
                  n_reported++;
               end
            end
         end
      end
      failures      <= n_err;
      waiting       <= deframed_q.size();
      frames_passed <= n_pass;
      frames_failed <= n_fail;
      body_bytes    <= n_body;
   end

endmodule

>>> bench/sync_frame_deframer_crc32_tb.sv
`timescale 1ns / 1ps

module sync_frame_deframer_crc32_tb;
   import sfd_pkg::*;

   localparam logic [7:0] BROKEN_SYNC [9] = '{8'hAA, 8'h13, 8'hAA, 8'h44, 8'h00,
                                               8'hAA, 8'h44, 8'hAA, 8'hAA};

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0]           pwdata;
   logic [31:0]           prdata;
   logic                  pready;

   sfd_req_if req ();
   sfd_rsp_if rsp ();

   int unsigned failures;
   int unsigned waiting;
   int unsigned frames_passed;
   int unsigned frames_failed;
   int unsigned body_bytes;

   logic [31:0] poly_now;
   logic [11:0] max_now;
   int unsigned bytes_sent   = 0;
   int unsigned burst_left   = 0;
   int unsigned phases_run   = 0;
   int unsigned hold_len     = 0;
   int unsigned holds_done   = 0;
   int unsigned pattern_left = 0;
   int unsigned pattern_sel  = 0;
   int unsigned stall_tick   = 0;
   bit          hold_request = 1'b0;

   sync_frame_deframer_crc32 i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req),
      .rsp_ch  (rsp),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   sfd_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req),
      .rsp_ch        (rsp),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .pready        (pready),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .failures      (failures),
      .waiting       (waiting),
      .frames_passed (frames_passed),
      .frames_failed (frames_failed),
      .body_bytes    (body_bytes)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // receiver: changing stall patterns, plus a long hold on request
   initial begin
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp.ready <= 1'b0;
            repeat (hold_len) @(posedge clock);
            holds_done++;
         end else begin
            if (pattern_left == 0) begin
               pattern_sel  = $urandom_range(0, 3);
               pattern_left = $urandom_range(16, 96);
            end
            pattern_left--;
            stall_tick++;
            case (pattern_sel)
               0: rsp.ready <= 1'b1;
               1: rsp.ready <= (stall_tick % 3 == 0);
               2: rsp.ready <= 1'($urandom_range(0, 1));
               default: rsp.ready <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      if (burst_left == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 12);
      end
      req.valid   <= 1'b1;
      req.in_byte <= b;
      burst_left--;
      do @(posedge clock); while (!req.ready);
      bytes_sent++;
   endtask

   task automatic send_frame(input logic [15:0] id, input logic [15:0] len, input bit corrupt);
      logic [7:0]  frame_q[$];
      logic [31:0] crc;
      int unsigned pos;
      frame_q = {SYNC0, SYNC1, SYNC2};
      for (pos = 3; pos < HEADER_LEN; pos++) frame_q.push_back(8'($urandom_range(0, 255)));
      frame_q[ID_OFFSET]      = id[7:0];
      frame_q[ID_OFFSET + 1]  = id[15:8];
      frame_q[LEN_OFFSET]     = len[7:0];
      frame_q[LEN_OFFSET + 1] = len[15:8];
      if (len <= max_now && HEADER_LEN + len + CRC_LEN <= FRAME_BUF) begin
         repeat (len) frame_q.push_back(8'($urandom_range(0, 255)));
         crc = '0;
         foreach (frame_q[i]) begin
            crc = crc ^ {24'd0, frame_q[i]};
            repeat (8) crc = crc[0] ? ((crc >> 1) ^ poly_now) : (crc >> 1);
         end
         if (corrupt) begin
            pos      = $urandom_range(0, 31);
            crc[pos] = ~crc[pos];
         end
         for (pos = 0; pos < CRC_LEN; pos++) frame_q.push_back(crc[8*pos +: 8]);
      end
      foreach (frame_q[i]) send_byte(frame_q[i]);
   endtask

   task automatic write_register(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (waiting != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic reconfigure(input logic [31:0] poly, input logic [11:0] max_len);
      drain();
      write_register({CSR_CRC_POLY, 2'b00}, poly);
      write_register({CSR_MAX_BODY, 2'b00}, {20'd0, max_len});
      poly_now   = poly;
      max_now    = max_len;
      burst_left = 0;
      phases_run++;
   endtask

   function automatic logic [15:0] good_len();
      int unsigned len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 200) : $urandom_range(0, 24);
      if (len > max_now || (max_now <= 200 && $urandom_range(0, 9) == 0)) len = 32'(max_now);
      return len[15:0];
   endfunction

   initial begin
      logic [15:0] id;
      logic [15:0] len;
      int unsigned target;
      int unsigned pick;
      req.valid   <= 1'b0;
      req.in_byte <= 8'h00;
      psel        <= 1'b0;
      penable     <= 1'b0;
      pwrite      <= 1'b0;
      paddr       <= '0;
      pwdata      <= '0;
      reset       <= 1'b1;
      poly_now     = CRC_POLY_RESET;
      max_now      = MAX_BODY_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      reconfigure(CRC_POLY_RESET, MAX_BODY_RESET);

      // sync broken at each step, with AA restarting the hunt
      foreach (BROKEN_SYNC[i]) send_byte(BROKEN_SYNC[i]);
      send_frame(ID_RANGE_OBS, 16'd0, 1'b0);
      send_frame(ID_GPS_EPH, 16'd3, 1'b0);
      send_frame(ID_RANGE_OBS, 16'd2, 1'b1);
      send_frame(ID_BDS_EPH, 16'd1, 1'b0);
      send_frame(ID_BEST_POS, 16'd5, 1'b0);
      send_frame(16'hFFFF, 16'd4, 1'b0);
      send_frame(16'h0000, 16'd4065, 1'b0);
      send_frame(16'hFFFF, 16'hFFFF, 1'b0);
      send_byte(8'h00);
      send_byte(8'hFF);

      // body limit above what the frame buffer holds
      reconfigure(CRC_POLY_RESET, 12'hFFF);
      send_frame(ID_RANGE_OBS, 16'd4065, 1'b0);
      send_frame(ID_GPS_EPH, 16'd4095, 1'b0);
      send_frame(ID_RANGE_OBS, 16'd7, 1'b0);

      reconfigure(32'h0000_0000, 12'd0);
      send_frame(ID_RANGE_OBS, 16'd0, 1'b0);
      send_frame(ID_GPS_EPH, 16'd1, 1'b0);
      send_frame(ID_BEST_POS, 16'd0, 1'b1);

      reconfigure(32'hFFFF_FFFF, 12'd16);
      send_frame(ID_RANGE_OBS, 16'd16, 1'b0);
      send_frame(ID_RANGE_OBS, 16'd17, 1'b0);

      // long receiver hold while a frame keeps coming
      reconfigure(CRC_POLY_RESET, MAX_BODY_RESET);
      hold_len     = 300;
      hold_request = 1'b1;
      send_frame(ID_RANGE_OBS, 16'd60, 1'b0);

      target = 1050;
      while (bytes_sent < target) begin
         case ($urandom_range(0, 4))
            0: reconfigure(CRC_POLY_RESET, MAX_BODY_RESET);
            1: reconfigure($urandom, 12'($urandom_range(0, 4095)));
            2: reconfigure($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000,
                           12'($urandom_range(0, 24)));
            default: reconfigure($urandom, 12'($urandom_range(0, 40)));
         endcase
         repeat ($urandom_range(4, 12)) begin
            if (bytes_sent < target) begin
               case ($urandom_range(0, 5))
                  0: id = ID_RANGE_OBS;
                  1: id = ID_GPS_EPH;
                  2: id = ID_BDS_EPH;
                  3: id = ID_BEST_POS;
                  4: id = 16'($urandom_range(0, 65535));
                  default: id = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
               endcase
               pick = $urandom_range(0, 99);
               if (pick < 55) begin
                  send_frame(id, good_len(), 1'b0);
               end else if (pick < 70) begin
                  send_frame(id, good_len(), 1'b1);
               end else if (pick < 80) begin
                  len = 16'($urandom_range(0, 1) ? max_now + 1
                                                 : $urandom_range(max_now + 1, 65535));
                  send_frame(id, len, 1'b0);
               end else if (pick < 90) begin
                  send_byte(SYNC0);
                  if ($urandom_range(0, 1)) send_byte(SYNC1);
                  send_byte(8'($urandom_range(0, 255)));
               end else begin
                  repeat ($urandom_range(1, 10)) send_byte(8'($urandom_range(0, 255)));
               end
            end
         end
      end

      drain();
      repeat (20) @(posedge clock);
      $display("run covered %0d stream bytes under %0d register settings, %0d long hold(s)",
               bytes_sent, phases_run, holds_done);
      $display("frames ending with good crc %0d, with bad crc %0d, body bytes %0d",
               frames_passed, frames_failed, body_bytes);
      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
